// ===== sv/hpa_pkg.sv =====
package hpa_pkg;

  // Binary16 field widths
  localparam int ManW = 10;
  localparam int ExpW = 5;
  localparam int SigW = 11;

  localparam logic [14:0] MagMax = 15'h7FFF;

  // Stage 1 -> stage 2: ordered operands
  typedef struct packed {
    logic             sign;
    logic             sub;
    logic [ExpW-1:0]  e_big;
    logic [SigW-1:0]  sig_big;
    logic [SigW-1:0]  sig_small;
  } align_t;

  // Stage 2 -> stage 3: raw sum
  typedef struct packed {
    logic             sign;
    logic [ExpW-1:0]  e_big;
    logic [11:0]      sum;
  } sum_t;

endpackage

// ===== sv/hpa_align.sv =====
module hpa_align (
  input  logic                clk,
  input  logic                adv,
  input  logic [15:0]         operand_a,
  input  logic [15:0]         operand_b,
  output hpa_pkg::align_t     align_q
);

  hpa_pkg::align_t align_next;
  logic        a_big;
  logic [15:0] big;
  logic [15:0] small_op;
  logic [5:0]  gap;
  logic [10:0] sig_s;

  // Order by magnitude, flush zero exponents, truncate-shift the smaller
  always_comb begin
    a_big = operand_a[14:0] >= operand_b[14:0];
    big = a_big ? operand_a : operand_b;
    small_op = a_big ? operand_b : operand_a;
    align_next.sub = operand_a[15] ^ operand_b[15];
    align_next.sign = big[15];
    align_next.e_big = big[14:10];
    align_next.sig_big = (big[14:10] == 5'd0) ? 11'd0 : {1'b1, big[9:0]};
    sig_s = (small_op[14:10] == 5'd0) ? 11'd0 : {1'b1, small_op[9:0]};
    gap = {1'b0, big[14:10]} - {1'b0, small_op[14:10]};
    align_next.sig_small = (gap >= 6'd11) ? 11'd0 : (sig_s >> gap[3:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      align_q <= align_next;
    end
  end

endmodule

// ===== sv/hpa_addsub.sv =====
module hpa_addsub (
  input  logic             clk,
  input  logic             adv,
  input  hpa_pkg::align_t  align_q,
  output hpa_pkg::sum_t    sum_q
);

  hpa_pkg::sum_t sum_next;
  logic [10:0] neg_small;

  // Add or subtract the aligned significands
  always_comb begin
    neg_small = (~align_q.sig_small) + 11'd1;
    sum_next.sign = align_q.sign;
    sum_next.e_big = align_q.e_big;
    if (align_q.sub) begin
      sum_next.sum = {1'b0, align_q.sig_big + neg_small};
    end else begin
      sum_next.sum = {1'b0, align_q.sig_big} + {1'b0, align_q.sig_small};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_q <= sum_next;
    end
  end

endmodule

// ===== sv/hpa_norm.sv =====
module hpa_norm (
  input  hpa_pkg::sum_t  sum_q,
  output logic [15:0]    result
);

  logic [3:0]  lead;
  logic [6:0]  expo;
  logic [11:0] norm;

  // Find the leading one, then normalize and clamp the exponent
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (sum_q.sum[i]) begin
        lead = 4'(i);
      end
    end
    expo = {2'b0, sum_q.e_big} + 7'd1 + {3'b0, lead} - 7'd11;
    if (lead == 4'd11) begin
      norm = sum_q.sum >> 1;
    end else begin
      norm = sum_q.sum << (4'd10 - lead);
    end
    if (sum_q.sum == 12'd0) begin
      result = {sum_q.sign, 15'd0};
    end else if (!expo[6] && expo >= 7'd32) begin
      result = {sum_q.sign, hpa_pkg::MagMax};
    end else if (expo[6] || expo == 7'd0) begin
      result = {sum_q.sign, 15'd0};
    end else begin
      result = {sum_q.sign, expo[4:0], norm[9:0]};
    end
  end

endmodule

// ===== sv/half_precision_adder_truncating_core.sv =====
// Channel | Direction | tdata fields (low bit up)
// s_axis  | in        | operand_a[15:0], operand_b[31:16]
// m_axis  | out       | sum_bits[15:0]
// Output is registered; one item per cycle unless m_axis stalls.
// Stages: order/align, add/subtract, normalize into the output register.
// Reset clears the stage valid bits only.
// A stall on m_axis holds the whole pipeline; no item is lost or repeated.
module half_precision_adder_truncating_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // sum_bits
);

  logic v1, v2, adv;
  hpa_pkg::align_t align_q;
  hpa_pkg::sum_t   sum_q;
  logic [15:0] result;

  // Advance all stages together whenever the output can move
  assign adv = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = adv;

  hpa_align u_align (.clk(clk), .adv(adv), .operand_a(s_axis_tdata[15:0]),
                     .operand_b(s_axis_tdata[31:16]), .align_q(align_q));
  hpa_addsub u_addsub (.clk(clk), .adv(adv), .align_q(align_q), .sum_q(sum_q));
  hpa_norm u_norm (.sum_q(sum_q), .result(result));

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      m_axis_tvalid <= v2;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (m_axis_tready || !m_axis_tvalid))
    else $error("ready mismatch");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    adv && v2 |=> m_axis_tvalid)
    else $error("item lost in pipeline");
`endif

endmodule
